[rtl/double_round_to_integral_assert.svh]
// Assertion macros for the round-to-integral block.
// Used by rtl/double_round_to_integral.sv; no other dependencies.
`ifndef DOUBLE_ROUND_TO_INTEGRAL_ASSERT_SVH
`define DOUBLE_ROUND_TO_INTEGRAL_ASSERT_SVH
`ifndef SYNTH
`define DRI_ASSERT(label, clk_s, rst_s, prop, msg) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (prop)) else $error(msg);
`define DRI_ASSERT_RST(label, clk_s, prop, msg) \
    label: assert property (@(posedge clk_s) (prop)) else $error(msg);
`else
`define DRI_ASSERT(label, clk_s, rst_s, prop, msg)
`define DRI_ASSERT_RST(label, clk_s, prop, msg)
`endif
`endif

[rtl/dri_pkg.sv]
// Package for the round-to-integral block: binary64 constants and mode codes.
// No dependencies.
package dri_pkg;
    localparam int unsigned DATA_W = 64;
    localparam logic [1:0] MODE_NEAR = 2'd0;
    localparam logic [1:0] MODE_DOWN = 2'd1;
    localparam logic [1:0] MODE_UP   = 2'd2;
    localparam logic [1:0] MODE_ZERO = 2'd3;
    localparam logic [10:0] EXP_BIAS    = 11'd1023;
    localparam logic [10:0] EXP_INTEG   = 11'd1075;
    localparam logic [10:0] EXP_SPECIAL = 11'h7FF;
    localparam logic [62:0] ONE_MAG  = 63'h3FF0000000000000;
    localparam logic [62:0] HALF_MAG = 63'h3FE0000000000000;
endpackage

[rtl/double_round_to_integral.sv]
// Top level of the round-to-integral block for binary64 values.
// Depends on dri_pkg and double_round_to_integral_assert.svh.
//
// Items arrive on the s_axis channel: tdata holds one binary64 pattern.
// The rounded pattern leaves on m_axis tdata. The rounding mode (nearest-even,
// down, up, toward zero) is written through cfg_wr_en/cfg_wr_data; the user
// must write it only while the block is idle, which the block does not enforce.
// NaN and infinity pass unchanged, and a zero result keeps the input's sign.
// The datapath has three register stages: mask build and decode, the
// rounding decision, then the increment and final select. An item passes
// through each stage in turn before its result shows on m_axis; one item is
// taken in every cycle while the output is taken.
// Each stage advances when it is empty or the stage after it moves, so a
// stall at the receiver holds every stage and loses nothing; s_axis_tready
// falls only when the whole pipeline is full.
// Reset clears the valid bits and sets the mode to nearest-even.
`include "double_round_to_integral_assert.svh"
module double_round_to_integral (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_wr_en,
    input  logic [1:0]                 cfg_wr_data,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic [dri_pkg::DATA_W-1:0] s_axis_tdata,  // [63:0] value_bits
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    output logic [dri_pkg::DATA_W-1:0] m_axis_tdata   // [63:0] result_bits
);
    import dri_pkg::*;

    logic [1:0]  mode_reg;
    logic        v1_reg, v2_reg, v3_reg;
    logic        adv1, adv2, adv3;

    logic [63:0] x1_reg, x2_reg;
    logic [62:0] mask1_reg, half1_reg, mask2_reg;
    logic        pass1_reg, small1_reg;
    logic        pass2_reg, small2_reg, inc2_reg, one2_reg;
    logic [63:0] res3_reg;

    logic [10:0] exp_in;
    logic [5:0]  fbits;
    logic [62:0] mask_next, half_next;

    assign adv3 = !v3_reg || m_axis_tready;
    assign adv2 = !v2_reg || adv3;
    assign adv1 = !v1_reg || adv2;
    assign s_axis_tready = adv1;

    assign exp_in = s_axis_tdata[62:52];
    assign fbits  = 6'(EXP_INTEG - exp_in);

    always_comb
    begin
        mask_next = (63'd1 << fbits) - 63'd1;
        half_next = (63'd1 << fbits) >> 1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_NEAR;
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
                mode_reg <= cfg_wr_data;
            if (adv1)
                v1_reg <= s_axis_tvalid;
            if (adv2)
                v2_reg <= v1_reg;
            if (adv3)
                v3_reg <= v2_reg;
        end
    end

    logic [62:0] mag1, frac1;
    logic        neg1, nz1, inc_c, one_c;

    always_comb
    begin
        mag1  = x1_reg[62:0];
        neg1  = x1_reg[63];
        frac1 = mag1 & mask1_reg;
        nz1   = frac1 != 63'd0;
        inc_c = 1'b0;
        one_c = 1'b0;
        unique case (mode_reg)
            MODE_NEAR:
            begin
                inc_c = (frac1 > half1_reg) ||
                        ((frac1 == half1_reg) && ((mag1 & (half1_reg << 1)) != 63'd0));
                one_c = mag1 > HALF_MAG;
            end
            MODE_DOWN:
            begin
                inc_c = neg1 && nz1;
                one_c = neg1 && (mag1 != 63'd0);
            end
            MODE_UP:
            begin
                inc_c = !neg1 && nz1;
                one_c = !neg1 && (mag1 != 63'd0);
            end
            MODE_ZERO:
            begin
                inc_c = 1'b0;
                one_c = 1'b0;
            end
            default:
            begin
                inc_c = 1'b0;
                one_c = 1'b0;
            end
        endcase
    end

    logic [62:0] kept2;

    always_comb
    begin
        kept2 = (x2_reg[62:0] & ~mask2_reg) + (inc2_reg ? (mask2_reg + 63'd1) : 63'd0);
    end

    always_ff @(posedge clk)
    begin
        if (adv1)
        begin
            x1_reg     <= s_axis_tdata;
            mask1_reg  <= mask_next;
            half1_reg  <= half_next;
            pass1_reg  <= (exp_in == EXP_SPECIAL) || (exp_in >= EXP_INTEG);
            small1_reg <= exp_in < EXP_BIAS;
        end
        if (adv2)
        begin
            x2_reg     <= x1_reg;
            mask2_reg  <= mask1_reg;
            pass2_reg  <= pass1_reg;
            small2_reg <= small1_reg;
            inc2_reg   <= inc_c;
            one2_reg   <= one_c;
        end
        if (adv3)
        begin
            if (pass2_reg)
                res3_reg <= x2_reg;
            else if (small2_reg)
                res3_reg <= {x2_reg[63], one2_reg ? ONE_MAG : 63'd0};
            else
                res3_reg <= {x2_reg[63], kept2};
        end
    end

    assign m_axis_tvalid = v3_reg;
    assign m_axis_tdata  = res3_reg;

    `DRI_ASSERT(a_hold_out, clk, rst_n, (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)), "stalled result changed")
    `DRI_ASSERT(a_full_stall, clk, rst_n, (!s_axis_tready) |-> (v1_reg && v2_reg && v3_reg), "input stalled with a free stage")
    `DRI_ASSERT(a_sign_kept, clk, rst_n, (m_axis_tvalid && !(res3_reg[62:52] == EXP_SPECIAL)) |-> (res3_reg[63] == $past(x2_reg[63]) || !$past(adv3)), "result sign differs from input")
    `DRI_ASSERT_RST(a_reset_empty, clk, (!rst_n) |-> (!m_axis_tvalid), "result valid during reset")
endmodule
